// ===== rtl/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int FRAME_W = 17;   // frame index wide enough for start + count
    localparam int CNT_W   = 16;
    localparam int START_W = 15;
    localparam logic [CNT_W-1:0] TOTAL_RESET = 16'd32768;

    typedef enum logic [1:0] {
        K_RELEASE  = 2'd0,
        K_RESERVE  = 2'd1,
        K_ALLOCATE = 2'd2,
        K_FREE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_RUN  = 2'd1,
        ST_ZERO    = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

endpackage

// ===== rtl/bfa_mask_unit.sv =====
// Bit-range set or clear of one map word.
`timescale 1ns / 1ps
module bfa_mask_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]         i_word,
    input  logic [$clog2(WORD_BITS)-1:0] i_lo,
    input  logic [$clog2(WORD_BITS)-1:0] i_hi,
    input  logic                         i_set,
    output logic [WORD_BITS-1:0]         o_word
);
    localparam int BW = $clog2(WORD_BITS);
    localparam logic [BW-1:0] TOP = BW'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] w_mask;

    // ones from bit lo up to bit hi inclusive
    assign w_mask = ({WORD_BITS{1'b1}} >> (TOP - i_hi)) & ({WORD_BITS{1'b1}} << i_lo);
    assign o_word = i_set ? (i_word | w_mask) : (i_word & ~w_mask);

endmodule

// ===== rtl/bitmap_frame_allocator_unit.sv =====
// Top level: bitmap frame allocator with word-serial map sequencer.
// Request flow: a zero count or a refused allocation goes straight to the result state;
//   a region operation reads and writes each map word touched; a release also sets frame 0.
// Allocation checks an all-used or all-free map word whole and a mixed word bit by bit,
//   then marks the run as a region; one request at a time, input held until done.
// Reset (synchronous, active low) and every total_frames write fill the map with ones.
`timescale 1ns / 1ps
module bitmap_frame_allocator_unit
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES = 32768,
    parameter int WORD_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: total_frames
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // start_frame[14:0], frame_count[30:15], zero pad
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // found_frame[14:0], used_count[30:15], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);
    localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [BW-1:0] TOP_BIT = BW'(WORD_BITS - 1);
    localparam logic [FRAME_W-1:0] WORD_FRAMES = FRAME_W'(WORD_BITS);
    localparam logic [CNT_W-1:0] EFF_RST =
        (NUM_FRAMES < 32768) ? CNT_W'(NUM_FRAMES) : TOTAL_RESET;
    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MPREP, S_MRD, S_MWR, S_F0RD, S_F0WR,
        S_ARD, S_AWORD, S_ABIT, S_DONE
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_eff;        // effective frame total
    logic [CNT_W-1:0]     r_used;
    t_kind                r_kind;
    logic [FRAME_W-1:0]   r_s;          // region start
    logic [CNT_W-1:0]     r_cnt;
    logic [FRAME_W-1:0]   r_endm1;      // last frame of clipped region
    logic [AW-1:0]        r_w;          // current map word
    logic [AW-1:0]        r_ws;         // first word of region
    logic [AW-1:0]        r_we;         // last word of region or scan
    logic                 r_set;
    logic [FRAME_W-1:0]   r_run;
    logic [BW-1:0]        r_bit;
    logic [WORD_BITS-1:0] r_word;
    logic [FRAME_W-1:0]   r_found;
    t_status              r_status;
    logic                 r_mv;
    logic [START_W-1:0]   r_o_found;
    logic [CNT_W-1:0]     r_o_used;
    t_status              r_o_status;

    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] w_marked;
    logic [BW-1:0]        w_lo, w_hi;
    logic [CNT_W-1:0]     w_cfg_eff;
    logic [START_W-1:0]   w_in_start;
    logic [CNT_W-1:0]     w_in_cnt;
    logic [FRAME_W-1:0]   w_end_raw, w_end, w_n, w_base;
    logic [FRAME_W:0]     w_sum;
    logic [FRAME_W-1:0]   w_effm1;
    logic [BW-1:0]        w_lastbit;
    logic [WORD_BITS-1:0] w_scan;
    logic [FRAME_W-1:0]   w_run1;

    assign w_in_start = i_s_tdata[14:0];
    assign w_in_cnt   = i_s_tdata[30:15];

    assign w_cfg_eff = (32'(i_cfg_data) < NUM_FRAMES) ? i_cfg_data : CNT_W'(NUM_FRAMES);

    // Clip the region to the total
    assign w_end_raw = r_s + FRAME_W'(r_cnt);
    assign w_end     = (w_end_raw > FRAME_W'(r_eff)) ? FRAME_W'(r_eff) : w_end_raw;
    assign w_n       = w_end - r_s;
    assign w_sum     = {1'b0, FRAME_W'(r_used)} + {1'b0, w_n};

    // Bit limits of the current word inside the region
    assign w_lo = (r_w == r_ws) ? r_s[BW-1:0]     : '0;
    assign w_hi = (r_w == r_we) ? r_endm1[BW-1:0] : TOP_BIT;

    bfa_mask_unit #(.WORD_BITS(WORD_BITS)) u_mask (
        .i_word (r_rd_data),
        .i_lo   (w_lo),
        .i_hi   (w_hi),
        .i_set  (r_set),
        .o_word (w_marked)
    );

    // Frames at or beyond the total count as used during the scan
    assign w_effm1   = FRAME_W'(r_eff) - FRAME_W'(1);
    assign w_lastbit = w_effm1[BW-1:0];
    assign w_scan    = (r_w == r_we) ?
                       (r_rd_data | ~(ALL_ONES >> (TOP_BIT - w_lastbit))) : r_rd_data;
    assign w_base    = FRAME_W'(r_w) << BW;
    assign w_run1    = r_run + FRAME_W'(1);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = ALL_ONES;
        unique case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_MWR: begin
                mem_we    = 1'b1;
                mem_wdata = w_marked;
            end
            S_F0WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data | WORD_BITS'(1);
            end
            default: mem_we = 1'b0;
        endcase
    end

    // Map memory: one write, one registered read, both at r_w
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_w] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_w];
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_m_tvalid  = r_mv;
    assign o_m_tdata   = {1'b0, r_o_used, r_o_found};
    assign o_m_tuser   = r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_eff    <= EFF_RST;
            r_used   <= EFF_RST;
            r_w      <= '0;
            r_mv     <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded now
            if (r_mv && i_m_tready && (r_state != S_DONE)) begin
                r_mv <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_w == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_w <= r_w + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_eff   <= w_cfg_eff;
                        r_used  <= w_cfg_eff;
                        r_w     <= '0;
                        r_state <= S_CLEAR;
                    end else if (i_s_tvalid) begin
                        r_kind   <= t_kind'(i_s_tuser);
                        r_s      <= FRAME_W'(w_in_start);
                        r_cnt    <= w_in_cnt;
                        r_found  <= '0;
                        r_status <= ST_DONE;
                        r_set    <= (t_kind'(i_s_tuser) == K_RESERVE);
                        r_run    <= '0;
                        r_w      <= '0;
                        r_we     <= AW'(w_effm1 >> BW);
                        if (w_in_cnt == '0) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_DONE;
                        end else if (t_kind'(i_s_tuser) == K_ALLOCATE) begin
                            if ((r_eff - r_used) < w_in_cnt) begin
                                r_status <= ST_NO_RUN;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_ARD;
                            end
                        end else begin
                            r_state <= S_MPREP;
                        end
                    end
                end
                S_MPREP: begin
                    if (r_s >= w_end) begin
                        r_w     <= '0;
                        r_state <= (r_kind == K_RELEASE) ? S_F0RD : S_DONE;
                    end else begin
                        r_w     <= AW'(r_s >> BW);
                        r_ws    <= AW'(r_s >> BW);
                        r_we    <= AW'((w_end - FRAME_W'(1)) >> BW);
                        r_endm1 <= w_end - FRAME_W'(1);
                        if (r_set) begin
                            r_used <= (w_sum > {1'b0, FRAME_W'(r_eff)}) ? r_eff
                                                                       : CNT_W'(w_sum);
                        end else begin
                            r_used <= (FRAME_W'(r_used) > w_n) ?
                                      CNT_W'(FRAME_W'(r_used) - w_n) : '0;
                        end
                        r_state <= S_MRD;
                    end
                end
                S_MRD: r_state <= S_MWR;
                S_MWR: begin
                    if (r_w == r_we) begin
                        r_w     <= '0;
                        r_state <= (r_kind == K_RELEASE) ? S_F0RD : S_DONE;
                    end else begin
                        r_w     <= r_w + AW'(1);
                        r_state <= S_MRD;
                    end
                end
                S_F0RD: r_state <= S_F0WR;
                S_F0WR: r_state <= S_DONE;
                S_ARD:  r_state <= S_AWORD;
                S_AWORD: begin
                    if (w_scan == ALL_ONES) begin
                        r_run <= '0;
                        if (r_w == r_we) begin
                            r_status <= ST_NO_RUN;
                            r_state  <= S_DONE;
                        end else begin
                            r_w     <= r_w + AW'(1);
                            r_state <= S_ARD;
                        end
                    end else if (w_scan == '0) begin
                        if (r_run + WORD_FRAMES >= FRAME_W'(r_cnt)) begin
                            r_found <= w_base - r_run;
                            r_s     <= w_base - r_run;
                            r_set   <= 1'b1;
                            r_state <= S_MPREP;
                        end else if (r_w == r_we) begin
                            r_status <= ST_NO_RUN;
                            r_state  <= S_DONE;
                        end else begin
                            r_run   <= r_run + WORD_FRAMES;
                            r_w     <= r_w + AW'(1);
                            r_state <= S_ARD;
                        end
                    end else begin
                        r_word  <= w_scan;
                        r_bit   <= '0;
                        r_state <= S_ABIT;
                    end
                end
                S_ABIT: begin
                    if (!r_word[r_bit] && (w_run1 == FRAME_W'(r_cnt))) begin
                        r_found <= w_base + FRAME_W'(r_bit) + FRAME_W'(1) - FRAME_W'(r_cnt);
                        r_s     <= w_base + FRAME_W'(r_bit) + FRAME_W'(1) - FRAME_W'(r_cnt);
                        r_set   <= 1'b1;
                        r_state <= S_MPREP;
                    end else begin
                        r_run <= r_word[r_bit] ? '0 : w_run1;
                        if (r_bit != TOP_BIT) begin
                            r_bit <= r_bit + BW'(1);
                        end else if (r_w == r_we) begin
                            r_status <= ST_NO_RUN;
                            r_state  <= S_DONE;
                        end else begin
                            r_w     <= r_w + AW'(1);
                            r_state <= S_ARD;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_mv || i_m_tready) begin
                        r_mv       <= 1'b1;
                        r_o_status <= r_status;
                        r_o_found  <= (r_status == ST_DONE) ? START_W'(r_found) : '0;
                        r_o_used   <= r_used;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Counter never passes the effective total
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_eff) else $error("used count above total");

    // A failed or empty request reports frame 0
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_DONE)) |-> (o_m_tdata[14:0] == '0))
        else $error("found frame set on failure");

    // A total_frames transfer starts the clearing pass
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_state == S_CLEAR))
        else $error("no clearing pass after configuration");

    // A request transfer leaves idle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request taken while busy");

endmodule
